### rtl/core/bpmc_pkg.sv
// Package for the button press mode controller: widths, reset values,
// register indexes, LED mode, press event and fade phase codes. No dependencies.
package bpmc_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int DUTY_W      = 8;
  localparam int FADE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  localparam logic [TIMER_WIDTH-1:0] DEBOUNCE_RESET  = 16'd50;
  localparam logic [TIMER_WIDTH-1:0] LONG_RESET      = 16'd3000;
  localparam logic [TIMER_WIDTH-1:0] VIBRATOR_RESET  = 16'd10000;
  localparam logic [TIMER_WIDTH-1:0] IDLE_RESET      = 16'd5000;
  localparam logic [FADE_W-1:0]      FADE_STEP_RESET = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_LONG      = 3'd1,
    REG_VIBRATOR  = 3'd2,
    REG_IDLE      = 3'd3,
    REG_FADE_STEP = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_RED  = 2'd1,
    MODE_FADE = 2'd2
  } led_mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  typedef enum logic [1:0] {
    PHASE_RG = 2'd0,
    PHASE_BR = 2'd1,
    PHASE_GB = 2'd2
  } fade_phase_t;

endpackage

### rtl/core/bpmc_ifs.sv
// Valid/ready channel interfaces for the button press mode controller:
// tick input beat and result beat. Depends on bpmc_pkg.
interface bpmc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface bpmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpmc_pkg::DUTY_W-1:0] red_duty;
  logic [bpmc_pkg::DUTY_W-1:0] green_duty;
  logic [bpmc_pkg::DUTY_W-1:0] blue_duty;
  logic                        vibrator_on;
  logic                        sleep_request;
  logic                        button_held;
  logic [1:0]                  led_mode;
  logic [1:0]                  press_event;

  modport source (output valid, output red_duty, output green_duty, output blue_duty,
                  output vibrator_on, output sleep_request, output button_held,
                  output led_mode, output press_event, input ready);
  modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                  input vibrator_on, input sleep_request, input button_held,
                  input led_mode, input press_event, output ready);
endinterface

### rtl/core/button_press_mode_controller_unit.sv
// Button press mode controller: input register, one-cycle state update, result register.
// Depends on bpmc_pkg and the channel interfaces in bpmc_ifs.sv.
// Tick beats pass the input register, then the result register; an untaken result stalls both.
// One tick beat per cycle if unstalled; the state update is one pass of compares and muxes.
// Reset (rst, synchronous): configuration registers take their default values, all state
// clears to released button, LED off, vibrator off, no sleep request; both registers empty.
module button_press_mode_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bpmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  bpmc_in_if.sink                            btn,
  bpmc_out_if.source                         res
);
  import bpmc_pkg::*;

  // configuration
  logic [TIMER_WIDTH-1:0] debounce_ticks;
  logic [TIMER_WIDTH-1:0] long_press_ticks;
  logic [TIMER_WIDTH-1:0] vibrator_ticks;
  logic [TIMER_WIDTH-1:0] idle_ticks;
  logic [FADE_W-1:0]      fade_step_ticks;

  // input register
  logic in_valid;
  logic in_level;
  logic advance;

  // state
  logic                   previous_raw;
  logic [TIMER_WIDTH-1:0] stable_count;
  logic                   debounced_level;
  logic                   long_seen;
  logic [1:0]             mode_reg;
  logic                   vibrator_active;
  logic [TIMER_WIDTH-1:0] vibrator_count;
  logic [TIMER_WIDTH-1:0] idle_count;
  logic                   sleep_flag;
  logic [DUTY_W-1:0]      red, green, blue;
  logic [1:0]             fade_phase;
  logic [FADE_W-1:0]      fade_index;
  logic [FADE_W-1:0]      fade_prescale;

  logic [TIMER_WIDTH-1:0] stable_count_next;
  logic                   debounced_level_next;
  logic                   long_seen_next;
  logic [1:0]             mode_reg_next;
  logic                   vibrator_active_next;
  logic [TIMER_WIDTH-1:0] vibrator_count_next;
  logic [TIMER_WIDTH-1:0] idle_count_next;
  logic                   sleep_flag_next;
  logic [DUTY_W-1:0]      red_next, green_next, blue_next;
  logic [1:0]             fade_phase_next;
  logic [FADE_W-1:0]      fade_index_next;
  logic [FADE_W-1:0]      fade_prescale_next;
  logic [1:0]             event_next;

  // output register
  logic out_valid;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign btn.ready = !in_valid || advance;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_RESET;
      vibrator_ticks   <= VIBRATOR_RESET;
      idle_ticks       <= IDLE_RESET;
      fade_step_ticks  <= FADE_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:  debounce_ticks   <= cfg_data;
        REG_LONG:      long_press_ticks <= cfg_data;
        REG_VIBRATOR:  vibrator_ticks   <= cfg_data;
        REG_IDLE:      idle_ticks       <= cfg_data;
        REG_FADE_STEP: fade_step_ticks  <= cfg_data[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [FADE_W-1:0] step;
    logic [FADE_W:0]   pre_inc;
    logic [DUTY_W-1:0] inv;
    logic              mode_off_next;

    red_next           = red;
    green_next         = green;
    blue_next          = blue;
    fade_phase_next    = fade_phase;
    fade_index_next    = fade_index;
    fade_prescale_next = fade_prescale;
    step               = (fade_step_ticks == '0) ? FADE_W'(1) : fade_step_ticks;
    pre_inc            = {1'b0, fade_prescale} + (FADE_W+1)'(1);
    inv                = DUTY_MAX - fade_index;

    case (mode_reg)
      MODE_RED: begin
        red_next   = DUTY_MAX;
        green_next = '0;
        blue_next  = '0;
      end
      MODE_FADE: begin
        if (fade_prescale == '0) begin
          case (fade_phase)
            PHASE_RG: begin
              red_next   = fade_index;
              green_next = inv;
            end
            PHASE_BR: begin
              blue_next = fade_index;
              red_next  = inv;
            end
            default: begin
              green_next = fade_index;
              blue_next  = inv;
            end
          endcase
          if (fade_index >= DUTY_MAX) begin
            fade_index_next = '0;
            fade_phase_next = (fade_phase >= PHASE_GB) ? PHASE_RG : fade_phase + 2'd1;
          end else begin
            fade_index_next = fade_index + FADE_W'(1);
          end
        end
        fade_prescale_next = (pre_inc >= {1'b0, step}) ? '0 : pre_inc[FADE_W-1:0];
      end
      default: begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
      end
    endcase

    vibrator_active_next = vibrator_active;
    vibrator_count_next  = vibrator_count;
    if (vibrator_active) begin
      if (vibrator_count <= TIMER_WIDTH'(1)) begin
        vibrator_active_next = 1'b0;
        vibrator_count_next  = '0;
      end else begin
        vibrator_count_next = vibrator_count - TIMER_WIDTH'(1);
      end
    end

    if (in_level != previous_raw) begin
      stable_count_next = '0;
    end else begin
      stable_count_next = (stable_count == TIMER_MAX) ? TIMER_MAX
                                                      : stable_count + TIMER_WIDTH'(1);
    end

    debounced_level_next = debounced_level;
    long_seen_next       = long_seen;
    event_next           = EV_NONE;
    if (stable_count_next > debounce_ticks) begin
      if (!in_level && debounced_level_next) begin
        debounced_level_next = 1'b0;
        long_seen_next       = 1'b0;
      end
      if (!debounced_level_next && stable_count_next > long_press_ticks && !long_seen_next) begin
        long_seen_next = 1'b1;
        event_next     = EV_LONG;
      end
      if (in_level && !debounced_level_next) begin
        debounced_level_next = 1'b1;
        if (!long_seen_next) event_next = EV_SHORT;
        long_seen_next = 1'b0;
      end
    end

    mode_reg_next = mode_reg;
    if (event_next == EV_SHORT) begin
      case (mode_reg)
        MODE_RED:  mode_reg_next = MODE_FADE;
        MODE_FADE: mode_reg_next = MODE_OFF;
        default:   mode_reg_next = MODE_RED;
      endcase
    end else if (event_next == EV_LONG) begin
      vibrator_active_next = 1'b1;
      vibrator_count_next  = vibrator_ticks;
    end

    mode_off_next   = (mode_reg_next != MODE_RED) && (mode_reg_next != MODE_FADE);
    sleep_flag_next = sleep_flag;
    if (mode_off_next && !vibrator_active_next) begin
      idle_count_next = (idle_count == TIMER_MAX) ? TIMER_MAX : idle_count + TIMER_WIDTH'(1);
      if (idle_count_next > idle_ticks) sleep_flag_next = 1'b1;
    end else begin
      idle_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      previous_raw    <= 1'b1;
      stable_count    <= '0;
      debounced_level <= 1'b1;
      long_seen       <= 1'b0;
      mode_reg        <= MODE_OFF;
      vibrator_active <= 1'b0;
      vibrator_count  <= '0;
      idle_count      <= '0;
      sleep_flag      <= 1'b0;
      red             <= '0;
      green           <= '0;
      blue            <= '0;
      fade_phase      <= PHASE_RG;
      fade_index      <= '0;
      fade_prescale   <= '0;
    end else begin
      if (btn.valid && btn.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        previous_raw    <= in_level;
        stable_count    <= stable_count_next;
        debounced_level <= debounced_level_next;
        long_seen       <= long_seen_next;
        mode_reg        <= mode_reg_next;
        vibrator_active <= vibrator_active_next;
        vibrator_count  <= vibrator_count_next;
        idle_count      <= idle_count_next;
        sleep_flag      <= sleep_flag_next;
        red             <= red_next;
        green           <= green_next;
        blue            <= blue_next;
        fade_phase      <= fade_phase_next;
        fade_index      <= fade_index_next;
        fade_prescale   <= fade_prescale_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (btn.valid && btn.ready) in_level <= btn.button_level;
    if (advance) begin
      res.red_duty      <= red_next;
      res.green_duty    <= green_next;
      res.blue_duty     <= blue_next;
      res.vibrator_on   <= vibrator_active_next;
      res.sleep_request <= sleep_flag_next;
      res.button_held   <= ~debounced_level_next;
      res.led_mode      <= mode_reg_next;
      res.press_event   <= event_next;
    end
  end

endmodule
